// ===== rtl/hba_pkg.sv =====
// ----------------------------------------------------------------------------
// Handle bitmap allocator package
// Shared codes, command and status bundles for the controller and datapath.
// ----------------------------------------------------------------------------
package hba_pkg;

  // Bitmap storage is organized in rows of WORD_W slots each.
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;
  // The slot field of a handle is bits 30 to 16.
  localparam int SLOT_W = 15;
  localparam int SLOT_LSB = 16;
  localparam int CAPS_W = 16;
  localparam int HOUT_W = 24;

  typedef enum logic [1:0] {
    MODE_OPEN  = 2'd0,
    MODE_CLOSE = 2'd1,
    MODE_CHECK = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_DENIED     = 2'd1,
    ST_FULL       = 2'd2,
    ST_BAD_HANDLE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_ZERO,
    WR_SET,
    WR_CLEAR
  } wr_op_e;

  typedef enum logic [1:0] {
    RES_PLAIN,
    RES_HANDLE,
    RES_FLAG
  } res_kind_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_UPDATE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic      load_item;
    logic      row_zero;
    logic      row_inc;
    logic      rd_next;
    wr_op_e    wr_op;
    logic      res_set;
    status_e   res_status;
    res_kind_e res_kind;
    logic      out_load;
  } hba_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  caps_ok;
    logic  slot_ok;
    logic  row_last;
    logic  free_found;
    logic  out_free;
  } hba_stat_t;

endpackage

// ===== rtl/hba_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module hba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/hba_ctrl.sv =====
// ----------------------------------------------------------------------------
// Handle bitmap allocator controller
// Sequences the clearing pass, the row scan and the read-modify-write steps.
// ----------------------------------------------------------------------------
module hba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  hba_pkg::hba_stat_t stat_i,
  output hba_pkg::hba_cmd_t  cmd_o
);

  import hba_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '{
      load_item:  1'b0,
      row_zero:   1'b0,
      row_inc:    1'b0,
      rd_next:    1'b0,
      wr_op:      WR_NONE,
      res_set:    1'b0,
      res_status: ST_OK,
      res_kind:   RES_PLAIN,
      out_load:   1'b0
    };
    in_stall_o = (state_q != S_IDLE);

    unique case (state_q)
      S_CLEAR: begin
        cmd_o.wr_op = WR_ZERO;
        if (stat_i.row_last) begin
          cmd_o.row_zero = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.row_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = S_DECIDE;
        end
      end
      // The row of the item is being read during this cycle.
      S_DECIDE: begin
        unique case (stat_i.mode)
          MODE_OPEN: begin
            if (stat_i.caps_ok) begin
              state_d = S_SCAN;
            end else begin
              cmd_o.res_set = 1'b1;
              cmd_o.res_status = ST_DENIED;
              state_d = S_DONE;
            end
          end
          MODE_CLOSE: begin
            if (stat_i.slot_ok) begin
              state_d = S_UPDATE;
            end else begin
              cmd_o.res_set = 1'b1;
              cmd_o.res_status = ST_BAD_HANDLE;
              state_d = S_DONE;
            end
          end
          MODE_CHECK: begin
            if (stat_i.slot_ok) begin
              state_d = S_UPDATE;
            end else begin
              cmd_o.res_set = 1'b1;
              state_d = S_DONE;
            end
          end
          default: begin
            cmd_o.res_set = 1'b1;
            state_d = S_DONE;
          end
        endcase
      end
      // One row per cycle: the next row is read while this one is examined.
      S_SCAN: begin
        cmd_o.rd_next = 1'b1;
        if (stat_i.free_found) begin
          cmd_o.wr_op = WR_SET;
          cmd_o.res_set = 1'b1;
          cmd_o.res_kind = RES_HANDLE;
          state_d = S_DONE;
        end else if (stat_i.row_last) begin
          cmd_o.res_set = 1'b1;
          cmd_o.res_status = ST_FULL;
          state_d = S_DONE;
        end else begin
          cmd_o.row_inc = 1'b1;
        end
      end
      S_UPDATE: begin
        cmd_o.res_set = 1'b1;
        if (stat_i.mode == MODE_CLOSE) begin
          cmd_o.wr_op = WR_CLEAR;
        end else begin
          cmd_o.res_kind = RES_FLAG;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/hba_datapath.sv =====
// ----------------------------------------------------------------------------
// Handle bitmap allocator datapath
// Item registers, bitmap RAM, first-free search and the output register.
// ----------------------------------------------------------------------------
module hba_datapath #(
  parameter int NUM_SLOTS = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [1:0]                    mode_i,
  input  logic [hba_pkg::CAPS_W-1:0]    capability_bits_i,
  input  logic signed [31:0]            handle_in_i,
  input  hba_pkg::hba_cmd_t             cmd_i,
  output hba_pkg::hba_stat_t            stat_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic [hba_pkg::HOUT_W-1:0]    handle_out_o,
  output logic                          open_flag_o
);

  import hba_pkg::*;

  localparam int ROWS      = (NUM_SLOTS + WORD_W - 1) / WORD_W;
  localparam int ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LAST_BITS = NUM_SLOTS - (ROWS - 1) * WORD_W;
  localparam logic [WORD_W:0] LastMaskW =
      ({{WORD_W{1'b0}}, 1'b1} << LAST_BITS) - {{WORD_W{1'b0}}, 1'b1};
  localparam logic [WORD_W-1:0] LastMask = LastMaskW[WORD_W-1:0];
  localparam logic [SLOT_W:0] SlotLimit = NUM_SLOTS[SLOT_W:0];

  mode_e              mode_q;
  logic [CAPS_W-1:0]  caps_q;
  logic [SLOT_W-1:0]  slot_q;
  logic               neg_q;
  logic [ROW_AW-1:0]  row_q;

  logic [WORD_W-1:0]  rdata;
  logic [WORD_W-1:0]  wdata;
  logic [ROW_AW-1:0]  raddr;
  logic [WORD_W-1:0]  row_mask;
  logic [WORD_W-1:0]  free_vec;
  logic [BIT_W-1:0]   free_bit;
  logic [SLOT_W:0]    found_slot;
  logic               row_last;
  logic               slot_ok;

  status_e            res_status_q;
  logic [HOUT_W-1:0]  res_handle_q;
  logic               res_flag_q;
  logic               out_valid_q;
  status_e            out_status_q;
  logic [HOUT_W-1:0]  out_handle_q;
  logic               out_flag_q;

  assign row_last = (row_q == ROW_AW'(ROWS - 1));
  assign slot_ok  = !neg_q && ({1'b0, slot_q} < SlotLimit);
  assign row_mask = row_last ? LastMask : '1;
  assign free_vec = ~rdata & row_mask;
  assign raddr    = cmd_i.rd_next ? (row_q + ROW_AW'(1)) : row_q;

  // Lowest free slot within the row.
  always_comb begin
    free_bit = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (free_vec[b]) begin
        free_bit = BIT_W'(b);
      end
    end
  end

  assign found_slot = (SLOT_W + 1)'({row_q, free_bit});

  always_comb begin
    unique case (cmd_i.wr_op)
      WR_SET:   wdata = rdata | (WORD_W'(1) << free_bit);
      WR_CLEAR: wdata = rdata & ~(WORD_W'(1) << slot_q[BIT_W-1:0]);
      default:  wdata = '0;
    endcase
  end

  hba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROWS),
    .AW    (ROW_AW)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_op != WR_NONE),
    .waddr_i (row_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else if (cmd_i.load_item) begin
      // Opens scan from the first row; close and check go to the handle's row.
      if (mode_e'(mode_i) == MODE_OPEN) begin
        row_q <= '0;
      end else begin
        row_q <= handle_in_i[SLOT_LSB + BIT_W +: ROW_AW];
      end
    end else if (cmd_i.row_zero) begin
      row_q <= '0;
    end else if (cmd_i.row_inc) begin
      row_q <= row_q + ROW_AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      mode_q <= mode_e'(mode_i);
      caps_q <= capability_bits_i;
      slot_q <= handle_in_i[SLOT_LSB +: SLOT_W];
      neg_q  <= handle_in_i[31];
    end
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_status;
      res_handle_q <= (cmd_i.res_kind == RES_HANDLE) ? {found_slot[7:0], caps_q} : '0;
      res_flag_q   <= (cmd_i.res_kind == RES_FLAG) ? rdata[slot_q[BIT_W-1:0]] : 1'b0;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_handle_q <= res_handle_q;
      out_flag_q   <= res_flag_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o = '{
    mode:       mode_q,
    caps_ok:    caps_q[0],
    slot_ok:    slot_ok,
    row_last:   row_last,
    free_found: |free_vec,
    out_free:   !out_valid_q || !out_stall_i
  };

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign handle_out_o = out_handle_q;
  assign open_flag_o  = out_flag_q;

endmodule

// ===== rtl/handle_bitmap_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Handle bitmap allocator
// Hands out, closes and checks handles against a bitmap of open slots.
// ----------------------------------------------------------------------------
// The bitmap lives in a RAM of ceil(NUM_SLOTS/32) rows of 32 slots. After
// reset the block clears that RAM one row per cycle and holds in_stall_o
// high meanwhile. It then works on one item at a time: an open with
// capability bit 0 set scans the rows from the first one until a free slot
// turns up or the last row is examined, since the single read port examines
// one row per cycle. Close and check pass through the decide and update
// steps, while refused or invalid requests go from decide straight to done.
// A finished result waits in the output register, so a new item is accepted
// while it is still stalled.
module handle_bitmap_allocator_unit #(
  parameter int NUM_SLOTS = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 mode_i,
  input  logic [hba_pkg::CAPS_W-1:0] capability_bits_i,
  input  logic signed [31:0]         handle_in_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic [hba_pkg::HOUT_W-1:0] handle_out_o,
  output logic                       open_flag_o
);

  import hba_pkg::*;

  hba_cmd_t  cmd;
  hba_stat_t stat;

  hba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  hba_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .mode_i            (mode_i),
    .capability_bits_i (capability_bits_i),
    .handle_in_i       (handle_in_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .handle_out_o      (handle_out_o),
    .open_flag_o       (open_flag_o)
  );

endmodule
